// File: rtl/thpa_pkg.sv
// Shared types and constants of the throttle hold PID assist.
package thpa_pkg;

   localparam int TARGET_SPEED_DEF = 0;
   localparam int THROTTLE_MAX_DEF = 4095;

   localparam int AW = 64;
   localparam int BW = 40;
   localparam int CW = 6;

   localparam logic [3:0] CFG_GAIN_P = 4'd0;
   localparam logic [3:0] CFG_GAIN_I = 4'd1;
   localparam logic [3:0] CFG_GAIN_D = 4'd2;
   localparam logic [3:0] CFG_LIMIT = 4'd3;
   localparam logic [3:0] CFG_CENTER = 4'd4;
   localparam logic [3:0] CFG_BAND = 4'd5;
   localparam logic [3:0] CFG_MOVE = 4'd6;
   localparam logic [3:0] CFG_TIMEOUT = 4'd7;

   localparam logic signed [63:0] INT_SAT = 64'sh0000_7FFF_FFFF_FFFF;

   typedef struct packed {
      logic start;
      logic div;
   } mdu_req_type;

   typedef struct packed {
      logic done;
      logic busy;
      logic [AW-1:0] res;
   } mdu_rsp_type;

endpackage

// File: rtl/thpa_mdu.sv
// Bit-serial unsigned multiplier and restoring divider.
module thpa_mdu (
   input logic clock,
   input logic reset,
   input thpa_pkg::mdu_req_type req,
   input logic [thpa_pkg::AW-1:0] a,
   input logic [thpa_pkg::BW-1:0] b,
   output thpa_pkg::mdu_rsp_type rsp
);
   import thpa_pkg::*;

   localparam logic [CW-1:0] DIV_LAST = CW'(AW - 1);

   logic busy_ff, busy_in, div_ff, div_in, done_ff, done_in;
   logic [AW-1:0] x_ff, x_in, acc_ff, acc_in;
   logic [BW-1:0] y_ff, y_in, rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [BW:0] trial;
   logic ge;

   always_comb begin
      busy_in = busy_ff;
      div_in = div_ff;
      x_in = x_ff;
      y_in = y_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      trial = {rem_ff, x_ff[AW-1]};
      ge = trial >= {1'b0, y_ff};
      if (req.start) begin
         busy_in = 1'b1;
         div_in = req.div;
         x_in = a;
         y_in = b;
         acc_in = '0;
         rem_in = '0;
         cnt_in = '0;
      end else if (busy_ff) begin
         if (div_ff) begin
            rem_in = ge ? BW'(trial - {1'b0, y_ff}) : trial[BW-1:0];
            x_in = {x_ff[AW-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end else if (y_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (y_ff[0]) acc_in = acc_ff + x_ff;
            x_in = {x_ff[AW-2:0], 1'b0};
            y_in = {1'b0, y_ff[BW-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      div_ff <= div_in;
      x_ff <= x_in;
      y_ff <= y_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done = done_ff;
   assign rsp.busy = busy_ff;
   assign rsp.res = div_ff ? x_ff : acc_ff;

endmodule

// File: rtl/throttle_hold_pid_assist.sv
// Top level: throttle pass-through with speed-holding PID assist.
//
// Input channel req_*: one word per control tick (throttle ADC sample,
// signed motor eRPM, millisecond timestamp, assist enable). Result channel
// rsp_*: one word per input word, the throttle to send. Both use valid/ready.
// Configuration is written through csr_we/csr_index/csr_wdata; the user must
// do so only while idle, not enforced by the block; an index above 7 is ignored.
//
// One word at a time passes through a sequencer that drives a single
// bit-serial multiply/divide unit. A multiply runs until no multiplier bit
// is left set, a divide through all 64 dividend bits. A pass-through word
// goes from the decide state straight to the output stage, a decay word
// first runs a multiply and a divide, a PID word the full PID chain. The next
// word can be taken in the cycle after the result enters the output register.
// Reset loads the default register values and clears the controller state.
// A stalled receiver holds the result in the output register; the block
// finishes at most one more word and then waits with req_ready low.
module throttle_hold_pid_assist #(
   parameter int TARGET_SPEED = thpa_pkg::TARGET_SPEED_DEF,
   parameter int THROTTLE_MAX = thpa_pkg::THROTTLE_MAX_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input logic [11:0] req_throttle_raw,
   input logic signed [17:0] req_motor_speed,
   input logic [31:0] req_now_ms,
   input logic req_assist_on,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic [11:0] rsp_throttle_out,
   input logic csr_we,
   input logic [3:0] csr_index,
   input logic [15:0] csr_wdata
);
   import thpa_pkg::*;

   localparam logic signed [18:0] TGT = 19'(TARGET_SPEED);
   localparam logic [12:0] TMAX = 13'(THROTTLE_MAX);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DECIDE = 4'd1;
   localparam logic [3:0] S_M_ED = 4'd2;
   localparam logic [3:0] S_M_P = 4'd3;
   localparam logic [3:0] S_M_I = 4'd4;
   localparam logic [3:0] S_D_I = 4'd5;
   localparam logic [3:0] S_M_D1 = 4'd6;
   localparam logic [3:0] S_M_D2 = 4'd7;
   localparam logic [3:0] S_D_D = 4'd8;
   localparam logic [3:0] S_CLAMP = 4'd9;
   localparam logic [3:0] S_D_IN = 4'd10;
   localparam logic [3:0] S_OPREP = 4'd11;
   localparam logic [3:0] S_D_OUT = 4'd12;
   localparam logic [3:0] S_M_DEC = 4'd13;
   localparam logic [3:0] S_D_DEC = 4'd14;
   localparam logic [3:0] S_FIN = 4'd15;

   logic [15:0] gain_p_ff;
   logic [13:0] gain_i_ff;
   logic [12:0] gain_d_ff;
   logic [6:0] limit_ff;
   logic [11:0] center_ff, band_ff, move_ff;
   logic [15:0] timeout_ff;

   logic [3:0] state_ff, state_in;
   logic opgo_ff, opgo_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [11:0] out_ff, out_in;

   logic [11:0] thr_ff, thr_in;
   logic signed [17:0] spd_ff, spd_in;
   logic [31:0] now_ff, now_in;
   logic on_ff, on_in;

   logic [11:0] last_thr_ff, last_thr_in;
   logic man_ff, man_in;
   logic [31:0] since_ff, since_in;
   logic signed [47:0] integ_ff, integ_in;
   logic signed [18:0] lerr_ff, lerr_in;
   logic [31:0] ltime_ff, ltime_in;
   logic signed [16:0] inner_ff, inner_in, outer_ff, outer_in;

   logic signed [18:0] e_ff, e_in;
   logic [31:0] d_ff, d_in;
   logic signed [63:0] sum_ff, sum_in;
   logic [63:0] tmp_ff, tmp_in;
   logic sgn_ff, sgn_in;
   logic [11:0] res_ff, res_in;

   mdu_req_type mdu_req;
   mdu_rsp_type mdu_rsp;
   logic [AW-1:0] mdu_a;
   logic [BW-1:0] mdu_b;

   logic signed [12:0] thr_diff, ctr_diff;
   logic [12:0] thr_mag, ctr_mag;
   logic jump, flag_n, in_band, is_op;
   logic [31:0] since_n, dt_c;
   logic [18:0] e_mag;
   logic signed [19:0] de;
   logic [19:0] de_mag;
   logic [47:0] integ_mag;
   logic signed [63:0] mres_s, accn, lim, outc;
   logic signed [16:0] out17, q17;
   logic signed [19:0] xsum, ysum;
   logic [12:0] v13;

   thpa_mdu u_mdu (
      .clock(clock),
      .reset(reset),
      .req(mdu_req),
      .a(mdu_a),
      .b(mdu_b),
      .rsp(mdu_rsp)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_throttle_out = out_ff;

   always_comb begin
      thr_diff = $signed({1'b0, thr_ff}) - $signed({1'b0, last_thr_ff});
      thr_mag = thr_diff[12] ? 13'(-thr_diff) : 13'(thr_diff);
      ctr_diff = $signed({1'b0, thr_ff}) - $signed({1'b0, center_ff});
      ctr_mag = ctr_diff[12] ? 13'(-ctr_diff) : 13'(ctr_diff);
      jump = thr_mag >= {1'b0, move_ff};
      since_n = jump ? now_ff : since_ff;
      flag_n = (jump || man_ff) && !((now_ff - since_n) > {16'b0, timeout_ff});
      in_band = !flag_n && (ctr_mag <= {1'b0, band_ff});
      dt_c = now_ff - ltime_ff;
      e_mag = e_ff[18] ? 19'(-e_ff) : 19'(e_ff);
      de = 20'(e_ff) - 20'(lerr_ff);
      de_mag = de[19] ? 20'(-de) : 20'(de);
      integ_mag = integ_ff[47] ? 48'(-integ_ff) : 48'(integ_ff);
      mres_s = $signed(mdu_rsp.res);
      accn = 64'(integ_ff) + (e_ff[18] ? -mres_s : mres_s);
      lim = $signed({49'b0, limit_ff, 8'b0});
      if (sum_ff > lim) outc = lim;
      else if (sum_ff < -lim) outc = -lim;
      else outc = sum_ff;
      out17 = 17'(outc);
      xsum = 20'(inner_ff) * 20'sd7 + 20'(out17) * 20'sd3;
      ysum = 20'(outer_ff) * 20'sd3 + 20'(inner_ff) * 20'sd7;
      q17 = $signed(17'(mdu_rsp.res));
      v13 = {1'b0, center_ff} + {6'b0, mdu_rsp.res[14:8]};
   end

   always_comb begin
      is_op = 1'b1;
      mdu_req.div = 1'b0;
      mdu_a = tmp_ff;
      mdu_b = '0;
      unique case (state_ff)
         S_M_ED: begin
            mdu_a = AW'(d_ff);
            mdu_b = BW'(e_mag);
         end
         S_M_P: begin
            mdu_a = AW'(e_mag);
            mdu_b = BW'(gain_p_ff);
         end
         S_M_I: begin
            mdu_a = AW'(integ_mag);
            mdu_b = BW'(gain_i_ff);
         end
         S_D_I: begin
            mdu_req.div = 1'b1;
            mdu_b = BW'(16000);
         end
         S_M_D1: begin
            mdu_a = AW'(de_mag);
            mdu_b = BW'(gain_d_ff);
         end
         S_M_D2: mdu_b = BW'(125);
         S_D_D: begin
            mdu_req.div = 1'b1;
            mdu_b = BW'({d_ff, 1'b0});
         end
         S_D_IN, S_D_OUT: begin
            mdu_req.div = 1'b1;
            mdu_b = BW'(10);
         end
         S_M_DEC: begin
            mdu_a = AW'(integ_mag);
            mdu_b = BW'(19);
         end
         S_D_DEC: begin
            mdu_req.div = 1'b1;
            mdu_b = BW'(20);
         end
         default: is_op = 1'b0;
      endcase
      mdu_req.start = is_op && !opgo_ff;
   end

   always_comb begin
      state_in = state_ff;
      opgo_in = opgo_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_in = out_ff;
      thr_in = thr_ff;
      spd_in = spd_ff;
      now_in = now_ff;
      on_in = on_ff;
      last_thr_in = last_thr_ff;
      man_in = man_ff;
      since_in = since_ff;
      integ_in = integ_ff;
      lerr_in = lerr_ff;
      ltime_in = ltime_ff;
      inner_in = inner_ff;
      outer_in = outer_ff;
      e_in = e_ff;
      d_in = d_ff;
      sum_in = sum_ff;
      tmp_in = tmp_ff;
      sgn_in = sgn_ff;
      res_in = res_ff;
      if (mdu_req.start) opgo_in = 1'b1;
      if (mdu_rsp.done) opgo_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               thr_in = req_throttle_raw;
               spd_in = req_motor_speed;
               now_in = req_now_ms;
               on_in = req_assist_on;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            res_in = thr_ff;
            if (!on_ff) begin
               man_in = 1'b0;
               integ_in = '0;
               state_in = S_FIN;
            end else begin
               man_in = flag_n;
               since_in = since_n;
               if (jump) integ_in = '0;
               last_thr_in = thr_ff;
               e_in = TGT - 19'(spd_ff);
               d_in = (dt_c == '0) ? 32'd1 : dt_c;
               state_in = in_band ? S_M_ED : S_M_DEC;
            end
         end
         S_M_ED: begin
            if (mdu_rsp.done) begin
               if (accn > INT_SAT) integ_in = 48'(INT_SAT);
               else if (accn < -INT_SAT) integ_in = 48'(-INT_SAT);
               else integ_in = 48'(accn);
               state_in = S_M_P;
            end
         end
         S_M_P: begin
            if (mdu_rsp.done) begin
               sum_in = e_ff[18] ? -(mres_s >>> 4) : (mres_s >>> 4);
               state_in = S_M_I;
            end
         end
         S_M_I: begin
            if (mdu_rsp.done) begin
               tmp_in = mdu_rsp.res;
               state_in = S_D_I;
            end
         end
         S_D_I: begin
            if (mdu_rsp.done) begin
               sum_in = sum_ff + (integ_ff[47] ? -mres_s : mres_s);
               state_in = S_M_D1;
            end
         end
         S_M_D1: begin
            if (mdu_rsp.done) begin
               tmp_in = mdu_rsp.res;
               state_in = S_M_D2;
            end
         end
         S_M_D2: begin
            if (mdu_rsp.done) begin
               tmp_in = mdu_rsp.res;
               state_in = S_D_D;
            end
         end
         S_D_D: begin
            if (mdu_rsp.done) begin
               sum_in = sum_ff + (de[19] ? -mres_s : mres_s);
               lerr_in = e_ff;
               ltime_in = now_ff;
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            tmp_in = 64'(xsum[19] ? 20'(-xsum) : 20'(xsum));
            sgn_in = xsum[19];
            state_in = S_D_IN;
         end
         S_D_IN: begin
            if (mdu_rsp.done) begin
               inner_in = sgn_ff ? -q17 : q17;
               state_in = (mdu_rsp.res > 64'd256) ? S_OPREP : S_FIN;
            end
         end
         S_OPREP: begin
            tmp_in = 64'(ysum[19] ? 20'(-ysum) : 20'(ysum));
            sgn_in = ysum[19];
            state_in = S_D_OUT;
         end
         S_D_OUT: begin
            if (mdu_rsp.done) begin
               outer_in = sgn_ff ? -q17 : q17;
               if (!sgn_ff && (mdu_rsp.res != '0)) begin
                  res_in = (v13 > TMAX) ? TMAX[11:0] : v13[11:0];
               end
               state_in = S_FIN;
            end
         end
         S_M_DEC: begin
            if (mdu_rsp.done) begin
               tmp_in = mdu_rsp.res;
               state_in = S_D_DEC;
            end
         end
         S_D_DEC: begin
            if (mdu_rsp.done) begin
               integ_in = integ_ff[47] ? -48'(mdu_rsp.res) : 48'(mdu_rsp.res);
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_in = res_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff <= 16'd4096;
         gain_i_ff <= 14'd410;
         gain_d_ff <= 13'd205;
         limit_ff <= 7'd50;
         center_ff <= 12'd2048;
         band_ff <= 12'd100;
         move_ff <= 12'd50;
         timeout_ff <= 16'd1000;
      end else if (csr_we) begin
         unique case (csr_index)
            CFG_GAIN_P: gain_p_ff <= csr_wdata;
            CFG_GAIN_I: gain_i_ff <= csr_wdata[13:0];
            CFG_GAIN_D: gain_d_ff <= csr_wdata[12:0];
            CFG_LIMIT: limit_ff <= csr_wdata[6:0];
            CFG_CENTER: center_ff <= csr_wdata[11:0];
            CFG_BAND: band_ff <= csr_wdata[11:0];
            CFG_MOVE: move_ff <= csr_wdata[11:0];
            CFG_TIMEOUT: timeout_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         opgo_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_thr_ff <= 12'd2048;
         man_ff <= 1'b0;
         since_ff <= '0;
         integ_ff <= '0;
         lerr_ff <= '0;
         ltime_ff <= '0;
         inner_ff <= '0;
         outer_ff <= '0;
      end else begin
         state_ff <= state_in;
         opgo_ff <= opgo_in;
         rsp_valid_ff <= rsp_valid_in;
         last_thr_ff <= last_thr_in;
         man_ff <= man_in;
         since_ff <= since_in;
         integ_ff <= integ_in;
         lerr_ff <= lerr_in;
         ltime_ff <= ltime_in;
         inner_ff <= inner_in;
         outer_ff <= outer_in;
      end
      out_ff <= out_in;
      thr_ff <= thr_in;
      spd_ff <= spd_in;
      now_ff <= now_in;
      on_ff <= on_in;
      e_ff <= e_in;
      d_ff <= d_in;
      sum_ff <= sum_in;
      tmp_ff <= tmp_in;
      sgn_ff <= sgn_in;
      res_ff <= res_in;
   end

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      mdu_req.start |-> !mdu_rsp.busy)
      else $error("arith unit restarted while busy");

   a_idle_no_op: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !opgo_ff && !mdu_rsp.busy)
      else $error("arith unit running while idle");

   a_integ_sat: assert property (@(posedge clock) disable iff (reset)
      integ_ff != {1'b1, 47'b0})
      else $error("integral beyond saturation");

   a_inner_range: assert property (@(posedge clock) disable iff (reset)
      (inner_ff <= 17'sd32512) && (inner_ff >= -17'sd32512))
      else $error("inner smoother out of range");

endmodule

// File: bench/tb_throttle_hold_pid_assist.sv
// Testbench for the throttle hold PID assist: directed and random words against a predictor.
`timescale 1ns / 100ps

module tb_throttle_hold_pid_assist;
   import thpa_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 400;
   localparam int HOLD_CYCLES = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [11:0] req_throttle_raw = '0;
   logic signed [17:0] req_motor_speed = '0;
   logic [31:0] req_now_ms = '0;
   logic req_assist_on = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [11:0] rsp_throttle_out;
   logic csr_we = 1'b0;
   logic [3:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   throttle_hold_pid_assist dut (.*);

   always #4 clock = ~clock;

   // predictor copy of registers and controller state
   longint gain_p, gain_i, gain_d, out_limit, center, band, move_thr, timeout_ms;
   logic [11:0] last_thr;
   bit manual_on;
   logic [31:0] manual_start;
   longint integ;
   longint last_err;
   logic [31:0] last_tick;
   longint inner_s, outer_s;

   logic [11:0] throttle_q[$];
   int errors = 0;
   int words_sent = 0;
   int words_checked = 0;
   int stall_count = 0;
   bit quiet = 1'b0;
   bit hold_rsp = 1'b0;
   logic [31:0] now_clk = 0;
   logic [11:0] cur_thr = 12'd2048;

   function automatic longint abs_l(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic [11:0] predict_throttle(logic [11:0] thr, logic signed [17:0] spd,
                                                    logic [31:0] now, bit on);
      longint e, acc, pid, lim, s1, v;
      logic [31:0] dt;
      if (!on) begin
         manual_on = 1'b0;
         integ = 0;
         return thr;
      end
      if (abs_l(longint'(thr) - longint'(last_thr)) >= move_thr) begin
         manual_on = 1'b1;
         manual_start = now;
         integ = 0;
      end
      if (manual_on && longint'({32'b0, now - manual_start}) > timeout_ms)
         manual_on = 1'b0;
      v = longint'(thr);
      if (!manual_on && abs_l(longint'(thr) - center) <= band) begin
         e = longint'(TARGET_SPEED_DEF) - longint'(spd);
         dt = now - last_tick;
         if (dt == 0) dt = 1;
         acc = integ + e * longint'({32'b0, dt});
         if (acc > INT_SAT) acc = INT_SAT;
         if (acc < -INT_SAT) acc = -INT_SAT;
         integ = acc;
         pid = (gain_p * e) / 16 + (gain_i * integ) / 16000
             + (gain_d * (e - last_err) * 125) / (2 * longint'({32'b0, dt}));
         lim = out_limit * 256;
         if (pid > lim) pid = lim;
         if (pid < -lim) pid = -lim;
         inner_s = (7 * inner_s + 3 * pid) / 10;
         last_err = e;
         last_tick = now;
         s1 = inner_s;
         if (abs_l(s1) > 256) begin
            outer_s = (3 * outer_s + 7 * s1) / 10;
            if (outer_s > 0) begin
               v = center + (outer_s >>> 8);
               if (v > THROTTLE_MAX_DEF) v = THROTTLE_MAX_DEF;
            end
         end
      end else begin
         integ = (integ * 19) / 20;
      end
      last_thr = thr;
      return v[11:0];
   endfunction

   task automatic write_reg(logic [3:0] idx, longint val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[15:0];
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CFG_GAIN_P: gain_p = val & 16'hFFFF;
         CFG_GAIN_I: gain_i = val & 14'h3FFF;
         CFG_GAIN_D: gain_d = val & 13'h1FFF;
         CFG_LIMIT: out_limit = val & 7'h7F;
         CFG_CENTER: center = val & 12'hFFF;
         CFG_BAND: band = val & 12'hFFF;
         CFG_MOVE: move_thr = val & 12'hFFF;
         CFG_TIMEOUT: timeout_ms = val & 16'hFFFF;
         default: ;
      endcase
   endtask

   task automatic set_regs(longint p, longint i, longint d, longint l, longint c,
                           longint b, longint m, longint t);
      write_reg(CFG_GAIN_P, p);
      write_reg(CFG_GAIN_I, i);
      write_reg(CFG_GAIN_D, d);
      write_reg(CFG_LIMIT, l);
      write_reg(CFG_CENTER, c);
      write_reg(CFG_BAND, b);
      write_reg(CFG_MOVE, m);
      write_reg(CFG_TIMEOUT, t);
   endtask

   task automatic send_word(logic [11:0] thr, logic signed [17:0] spd, logic [31:0] now, bit on);
      @(negedge clock);
      if (!quiet && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_throttle_raw <= thr;
      req_motor_speed <= spd;
      req_now_ms <= now;
      req_assist_on <= on;
      do @(posedge clock); while (!req_ready);
      throttle_q.push_back(predict_throttle(thr, spd, now, on));
      words_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (throttle_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one random word: mostly steady ticks near neutral, sometimes noise
   task automatic send_random();
      logic [11:0] thr;
      logic signed [17:0] spd;
      bit on;
      int pick;
      pick = $urandom_range(99);
      now_clk = now_clk + $urandom_range(20);
      if (pick < 6) now_clk = $urandom;
      on = ($urandom_range(99) < 92);
      if (pick < 10) cur_thr = 12'($urandom);
      else if (pick < 15) cur_thr = 12'(center + longint'($urandom_range(300)) - 150);
      else cur_thr = 12'(center + longint'($urandom_range(band > 40 ? 40 : band)) -
                         (band > 40 ? 20 : band / 2));
      thr = cur_thr;
      if ($urandom_range(99) < 20) spd = 18'($urandom);
      else spd = -18'sd2000 + $signed({1'b0, 12'($urandom_range(3000))});
      send_word(thr, spd, now_clk, on);
   endtask

   task automatic run_random(int n);
      repeat (n) send_random();
   endtask

   task automatic test_directed();
      send_word(12'd2048, 18'sd0, 32'd0, 1'b0);
      send_word(12'd0, -18'sd131072, 32'd0, 1'b0);
      send_word(12'd4095, 18'sd131071, 32'hFFFF_FFFF, 1'b0);
      send_word(12'd2048, -18'sd131072, 32'd10, 1'b1);
      send_word(12'd2050, -18'sd131072, 32'd10, 1'b1);
      send_word(12'd2040, -18'sd131072, 32'd30, 1'b1);
      send_word(12'd2048, -18'sd100000, 32'd50, 1'b1);
      send_word(12'd2048, 18'sd131071, 32'd60, 1'b1);
      send_word(12'd4095, -18'sd5000, 32'd70, 1'b1);
      send_word(12'd4095, -18'sd5000, 32'd500, 1'b1);
      send_word(12'd4095, -18'sd5000, 32'd1071, 1'b1);
      send_word(12'd2048, -18'sd5000, 32'd1200, 1'b1);
      send_word(12'd2048, -18'sd5000, 32'd2300, 1'b1);
      send_word(12'd2048, -18'sd5000, 32'hFFFF_FFF0, 1'b1);
      send_word(12'd2048, -18'sd5000, 32'h0000_0005, 1'b1);
      send_word(12'd0, 18'sd0, 32'd20, 1'b1);
      send_word(12'd2148, 18'sd0, 32'd40, 1'b1);
      send_word(12'd2149, 18'sd0, 32'd40, 1'b1);
      send_word(12'd1948, -18'sd3000, 32'd3000, 1'b1);
      send_word(12'd2048, -18'sd3000, 32'd3001, 1'b0);
      drain();
   endtask

   task automatic test_max_regs();
      set_regs(40960, 8192, 4096, 100, 4095, 4095, 4095, 0);
      write_reg(4'd8, 16'hFFFF);
      write_reg(4'd15, 16'h1234);
      send_word(12'd4095, -18'sd131072, 32'd0, 1'b1);
      send_word(12'd4095, -18'sd131072, 32'd1, 1'b1);
      run_random(120);
      drain();
   endtask

   task automatic test_min_regs();
      set_regs(0, 0, 0, 10, 0, 0, 0, 65535);
      send_word(12'd0, 18'sd0, 32'd0, 1'b1);
      run_random(60);
      drain();
      set_regs(16'hFFFF, 14'h3FFF, 13'h1FFF, 0, 2048, 200, 4095, 1000);
      run_random(60);
      drain();
   endtask

   task automatic test_random_sweep();
      set_regs(4096, 410, 205, 50, 2048, 100, 50, 1000);
      quiet = 1'b1;
      run_random(150);
      quiet = 1'b0;
      drain();
      set_regs(20000, 4000, 2000, 80, 1500, 300, 400, 40);
      run_random(200);
      drain();
      set_regs($urandom_range(40960), $urandom_range(8192), $urandom_range(4096),
               $urandom_range(100, 10), $urandom_range(4095), $urandom_range(400),
               $urandom_range(600), $urandom_range(3000));
      run_random(150);
      drain();
   endtask

   task automatic test_backpressure();
      set_regs(8192, 1000, 500, 100, 2048, 150, 200, 100);
      hold_rsp = 1'b1;
      run_random(130);
      drain();
   endtask

   always @(negedge clock) begin
      if (hold_rsp) begin
         rsp_ready <= 1'b0;
         repeat (HOLD_CYCLES) @(negedge clock);
         hold_rsp = 1'b0;
      end else begin
         rsp_ready <= quiet || ($urandom_range(99) >= 14);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (throttle_q.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual throttle_out %0d",
                     $time, rsp_throttle_out);
            errors++;
         end else begin
            if (rsp_throttle_out !== throttle_q[0]) begin
               $display("%0t: throttle_out mismatch, expected %0d, actual %0d",
                        $time, throttle_q[0], rsp_throttle_out);
               errors++;
            end
            void'(throttle_q.pop_front());
            words_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) stall_count <= 0;
      else stall_count <= stall_count + 1;
      if (stall_count >= WATCHDOG_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      gain_p = 4096; gain_i = 410; gain_d = 205; out_limit = 50;
      center = 2048; band = 100; move_thr = 50; timeout_ms = 1000;
      last_thr = 12'd2048; manual_on = 1'b0; manual_start = 0; integ = 0;
      last_err = 0; last_tick = 0; inner_s = 0; outer_s = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_max_regs();
      test_min_regs();
      test_random_sweep();
      test_backpressure();
      if (throttle_q.size() != 0) begin
         $display("%0t: %0d words still expected, actual none", $time, throttle_q.size());
         errors++;
      end
      $display("Ran %0d words (%0d checked) over default, extreme and random register sets,",
               words_sent, words_checked);
      $display("with manual override, neutral band, dt wrap and long output stall cases.");
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/thpa_pkg.sv
rtl/thpa_mdu.sv
rtl/throttle_hold_pid_assist.sv
bench/tb_throttle_hold_pid_assist.sv
